@@ rtl/stsyn_pkg.sv @@
package stsyn_pkg;

  localparam int unsigned Q_ONE       = 8388608;
  localparam int unsigned HALF_PI_Q30 = 1686629713;
  localparam int unsigned PARTIAL_FRAC = 42949673;
  localparam int unsigned K_LOWPASS   = 1342177;
  localparam int unsigned K_NOISE_MIX = 6543114;
  localparam int unsigned K_SINE_MIX  = 2936013;
  localparam int unsigned K_PARTIAL   = 1509949;
  localparam logic [31:0] NOISE_SEED  = 32'h5eedc0de;

  localparam int unsigned MUL_A_W = 34;
  localparam int unsigned MUL_B_W = 32;
  localparam int unsigned MUL_P_W = MUL_A_W + MUL_B_W;
  localparam int unsigned DIV_N_W = MUL_A_W + 13;
  localparam int unsigned V_W     = 36;

  localparam logic [2:0] CFG_SAMPLE_COUNT = 3'd0;
  localparam logic [2:0] CFG_STEP_START   = 3'd1;
  localparam logic [2:0] CFG_STEP_SLOPE   = 3'd2;
  localparam logic [2:0] CFG_WAVEFORM     = 3'd3;
  localparam logic [2:0] CFG_DECAY_RATIO  = 3'd4;
  localparam logic [2:0] CFG_OUTPUT_GAIN  = 3'd5;
  localparam logic [2:0] CFG_FADE_ENABLE  = 3'd6;

  localparam logic [1:0] WAVE_SINE     = 2'd0;
  localparam logic [1:0] WAVE_TRIANGLE = 2'd1;
  localparam logic [1:0] WAVE_SQUARE   = 2'd2;
  localparam logic [1:0] WAVE_NOISE    = 2'd3;

  typedef enum logic [4:0] {
    ST_IDLE, ST_PHASE, ST_PFRAC,
    ST_W0_RD, ST_W0_MUL, ST_W0_WAIT, ST_W0_RD2, ST_W0_SUM,
    ST_N_LFSR, ST_N_LPM, ST_N_LPW, ST_N_MIXM, ST_N_MIXW, ST_N_RD, ST_N_SINM, ST_N_SINW,
    ST_ENV_M, ST_ENV_W, ST_GAIN_M, ST_GAIN_W,
    ST_FI_M, ST_FI_W, ST_FI_DW, ST_FO_M, ST_FO_W, ST_FO_DW,
    ST_OUT, ST_DEC_W, ST_EMIT
  } state_t;

  function automatic logic [23:0] sine_entry(input int unsigned k, input int unsigned bits);
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] term;
    logic signed [63:0] sum;
    logic signed [63:0] q;
    x = (64'(k) * 64'(HALF_PI_Q30)) >> bits;
    x2 = (x * x) >> 30;
    term = x;
    sum = $signed(x);
    for (int t = 1; t <= 7; t++) begin
      term = (term * x2) >> 30;
      case (t)
        1: term = term / 64'd6;
        2: term = term / 64'd20;
        3: term = term / 64'd42;
        4: term = term / 64'd72;
        5: term = term / 64'd110;
        6: term = term / 64'd156;
        default: term = term / 64'd210;
      endcase
      if (t % 2 == 1) sum = sum - $signed(term);
      else sum = sum + $signed(term);
    end
    if (sum < 0) sum = 0;
    q = (sum + 64) >>> 7;
    if (q > 64'(Q_ONE)) q = 64'(Q_ONE);
    return q[23:0];
  endfunction

endpackage

@@ rtl/stsyn_smul.sv @@
module stsyn_smul import stsyn_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic [MUL_A_W-1:0] a,
  input  logic [MUL_B_W-1:0] b,
  output logic               done,
  output logic [MUL_P_W-1:0] prod
);

  localparam int unsigned CNT_W = $clog2(MUL_B_W);

  logic [MUL_A_W-1:0] acand;
  logic [CNT_W-1:0]   cnt;
  logic               busy;
  logic [MUL_A_W:0]   sum;

  assign sum = {1'b0, prod[MUL_P_W-1:MUL_B_W]} + {1'b0, acand};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        prod  <= {{MUL_A_W{1'b0}}, b};
        acand <= a;
        cnt   <= '0;
        busy  <= 1'b1;
      end else if (busy) begin
        if (prod[0]) prod <= {sum, prod[MUL_B_W-1:1]};
        else prod <= {1'b0, prod[MUL_P_W-1:1]};
        cnt <= cnt + 1'b1;
        if (cnt == CNT_W'(MUL_B_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

@@ rtl/stsyn_sdiv.sv @@
module stsyn_sdiv import stsyn_pkg::*; #(
  parameter int unsigned DIVISOR = 220
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic [DIV_N_W-1:0] num,
  output logic               done,
  output logic [DIV_N_W-1:0] quot
);

  localparam int unsigned D_W   = $clog2(DIVISOR + 1);
  localparam int unsigned CNT_W = $clog2(DIV_N_W);

  logic [D_W-1:0]   rem;
  logic [D_W:0]     trial;
  logic [D_W:0]     diff;
  logic             ge;
  logic [CNT_W-1:0] cnt;
  logic             busy;

  assign trial = {rem, quot[DIV_N_W-1]};
  assign ge    = trial >= (D_W + 1)'(DIVISOR);
  assign diff  = trial - (D_W + 1)'(DIVISOR);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        quot <= num;
        rem  <= '0;
        cnt  <= '0;
        busy <= 1'b1;
      end else if (busy) begin
        rem  <= ge ? diff[D_W-1:0] : trial[D_W-1:0];
        quot <= {quot[DIV_N_W-2:0], ge};
        cnt  <= cnt + 1'b1;
        if (cnt == CNT_W'(DIV_N_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

@@ rtl/swept_tone_synth_unit.sv @@
// Request-to-result time depends on the waveform (sine and noise take extra products),
// on each active fade edge and on any output stall.
// One request is worked on at a time; the next can be taken in the cycle after the result
// is issued. Products come from a bit-serial multiplier and fade quotients from a
// bit-serial divider. Reset (rst, synchronous, active high) loads the register
// defaults and clears the sound state; the sine table is constant.
module swept_tone_synth_unit import stsyn_pkg::*; #(
  parameter int unsigned SINE_TABLE_BITS = 10,
  parameter int unsigned FADE_LENGTH     = 220,
  parameter int unsigned COUNT_BITS      = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [0] restart
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // [15:0] sample
  output logic        m_tlast,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  localparam int unsigned TAB_N    = 1 << SINE_TABLE_BITS;
  localparam int unsigned TAB_SIZE = TAB_N + 1;
  localparam int unsigned ADDR_W   = SINE_TABLE_BITS + 1;
  localparam int unsigned CNT_W    = COUNT_BITS;

  typedef logic [23:0] rom_t [TAB_SIZE];

  function automatic rom_t build_rom();
    rom_t r;
    for (int k = 0; k < TAB_SIZE; k++) r[k] = sine_entry(k, SINE_TABLE_BITS);
    return r;
  endfunction

  localparam rom_t SINE_ROM = build_rom();

  logic [15:0] sample_count;
  logic [31:0] step_start;
  logic [31:0] step_slope;
  logic [1:0]  waveform;
  logic [23:0] decay_ratio;
  logic [23:0] output_gain;
  logic        fade_enable;

  logic [31:0]            phase;
  logic [31:0]            partial_phase;
  logic [31:0]            phase_step;
  logic [CNT_W-1:0]       sample_index;
  logic [23:0]            envelope;
  logic signed [24:0]     lowpass;
  logic [31:0]            noise_word;
  logic                   running;

  state_t state, state_next;

  logic [CNT_W-1:0]       idx_q;
  logic [CNT_W-1:0]       count_q;
  logic signed [V_W-1:0]  v;
  logic signed [V_W-1:0]  tmp;
  logic signed [25:0]     diff_q;
  logic [23:0]            rom_q;
  logic                   mul_neg;
  logic [15:0]            samp_q;
  logic                   last_q;

  logic               mul_start;
  logic [MUL_A_W-1:0] mul_a;
  logic [MUL_B_W-1:0] mul_b;
  logic               op_neg;
  logic               mul_done;
  logic [MUL_P_W-1:0] mul_prod;
  logic               div_start;
  logic               div_done;
  logic [DIV_N_W-1:0] div_quot;
  logic               rom_pp;

  logic [CNT_W-1:0]       count_raw;
  logic [CNT_W-1:0]       rem_v;
  logic                   fade_in;
  logic                   fade_out;
  logic                   last_v;
  logic                   emit_fire;
  logic                   accept;
  logic [31:0]            rom_ph;
  logic [SINE_TABLE_BITS-1:0] tab_idx;
  logic [ADDR_W-1:0]      rom_addr;
  logic signed [V_W-1:0]  sine_s;
  logic [V_W-1:0]         v_abs;
  logic [MUL_P_W-1:0]     prod_r23;
  logic [MUL_P_W-1:0]     prod_r16;
  logic signed [V_W-1:0]  s23;
  logic signed [V_W-1:0]  s16;
  logic signed [V_W-1:0]  q_s;
  logic [24:0]            tri_p;
  logic signed [V_W-1:0]  tri_v;
  logic [31:0]            nw1, nw2, nw3;
  logic signed [24:0]     nz;
  logic [25:0]            diff_abs;
  logic [24:0]            lp_abs;
  logic signed [V_W-1:0]  vc;
  logic [23:0]            cmag;
  logic [38:0]            m39;
  logic [15:0]            mag_q;
  logic [15:0]            mag_r;
  logic [MUL_P_W-1:0]     env_r;
  logic [DIV_N_W-1:0]     div_num;

  assign cfg_ready = 1'b1;
  assign s_tready  = (state == ST_IDLE);
  assign accept    = s_tvalid && s_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      sample_count <= 16'd1;
      step_start   <= '0;
      step_slope   <= '0;
      waveform     <= WAVE_SINE;
      decay_ratio  <= 24'(Q_ONE);
      output_gain  <= 24'd65536;
      fade_enable  <= 1'b1;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_SAMPLE_COUNT: sample_count <= cfg_data[15:0];
        CFG_STEP_START:   step_start   <= cfg_data;
        CFG_STEP_SLOPE:   step_slope   <= cfg_data;
        CFG_WAVEFORM:     waveform     <= cfg_data[1:0];
        CFG_DECAY_RATIO:  decay_ratio  <= cfg_data[23:0];
        CFG_OUTPUT_GAIN:  output_gain  <= cfg_data[23:0];
        CFG_FADE_ENABLE:  fade_enable  <= cfg_data[0];
        default: ;
      endcase
    end
  end

  assign count_raw = CNT_W'(sample_count);
  assign rem_v     = (count_q > idx_q) ? count_q - idx_q : '0;
  assign fade_in   = fade_enable && (32'(idx_q) < FADE_LENGTH);
  assign fade_out  = fade_enable && (32'(rem_v) < FADE_LENGTH);
  assign last_v    = ({1'b0, idx_q} + 1'b1) >= {1'b0, count_q};

  assign rom_ph   = rom_pp ? partial_phase : phase;
  assign tab_idx  = rom_ph[29 -: SINE_TABLE_BITS];
  assign rom_addr = rom_ph[30] ? ADDR_W'(TAB_N) - {1'b0, tab_idx} : {1'b0, tab_idx};
  assign sine_s   = phase[31] ? -$signed({12'b0, rom_q}) : $signed({12'b0, rom_q});

  always_ff @(posedge clk) begin
    rom_q <= SINE_ROM[rom_addr];
  end

  assign v_abs    = v[V_W-1] ? V_W'(-v) : V_W'(v);
  assign prod_r23 = mul_prod + (MUL_P_W'(1) << 22);
  assign prod_r16 = mul_prod + (MUL_P_W'(1) << 15);
  assign s23 = mul_neg ? -$signed({1'b0, prod_r23[57:23]}) : $signed({1'b0, prod_r23[57:23]});
  assign s16 = mul_neg ? -$signed({1'b0, prod_r16[50:16]}) : $signed({1'b0, prod_r16[50:16]});
  assign q_s = mul_neg ? -$signed({2'b0, div_quot[MUL_A_W-1:0]})
                       : $signed({2'b0, div_quot[MUL_A_W-1:0]});

  assign tri_p = phase[31:7];
  always_comb begin
    if (tri_p < 25'(Q_ONE)) tri_v = $signed(V_W'(tri_p));
    else if (tri_p < 25'(3 * Q_ONE)) tri_v = $signed(V_W'(2 * Q_ONE)) - $signed(V_W'(tri_p));
    else tri_v = $signed(V_W'(tri_p)) - $signed(V_W'(4 * Q_ONE));
  end

  assign nw1 = noise_word ^ (noise_word << 13);
  assign nw2 = nw1 ^ (nw1 >> 17);
  assign nw3 = nw2 ^ (nw2 << 5);
  assign nz  = $signed({1'b0, nw3[31:8]}) - $signed(25'(Q_ONE));
  assign diff_abs = diff_q[25] ? 26'(-diff_q) : 26'(diff_q);
  assign lp_abs   = lowpass[24] ? 25'(-lowpass) : 25'(lowpass);

  always_comb begin
    if (v > $signed(V_W'(Q_ONE))) vc = $signed(V_W'(Q_ONE));
    else if (v < -$signed(V_W'(Q_ONE))) vc = -$signed(V_W'(Q_ONE));
    else vc = v;
  end
  assign cmag  = vc[V_W-1] ? 24'(-vc) : 24'(vc);
  assign m39   = ({15'b0, cmag} << 15) - {15'b0, cmag};
  assign mag_r = ((m39[22:0] > 23'(Q_ONE / 2)) ||
                  ((m39[22:0] == 23'(Q_ONE / 2)) && m39[23])) ?
                 m39[38:23] + 16'd1 : m39[38:23];
  assign mag_q = vc[V_W-1] ? -mag_r : mag_r;

  assign env_r   = mul_prod + (MUL_P_W'(1) << 22);
  assign div_num = mul_prod[DIV_N_W-1:0] + DIV_N_W'(FADE_LENGTH / 2);

  assign emit_fire = (state == ST_EMIT) && (!m_tvalid || m_tready);

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:    if (s_tvalid && (s_tdata[0] || running)) state_next = ST_PHASE;
      ST_PHASE:   state_next = ST_PFRAC;
      ST_PFRAC: begin
        if (mul_done) begin
          case (waveform)
            WAVE_SINE:  state_next = ST_W0_RD;
            WAVE_NOISE: state_next = ST_N_LFSR;
            default:    state_next = ST_ENV_M;
          endcase
        end
      end
      ST_W0_RD:   state_next = ST_W0_MUL;
      ST_W0_MUL:  state_next = ST_W0_WAIT;
      ST_W0_WAIT: if (mul_done) state_next = ST_W0_RD2;
      ST_W0_RD2:  state_next = ST_W0_SUM;
      ST_W0_SUM:  state_next = ST_ENV_M;
      ST_N_LFSR:  state_next = ST_N_LPM;
      ST_N_LPM:   state_next = ST_N_LPW;
      ST_N_LPW:   if (mul_done) state_next = ST_N_MIXM;
      ST_N_MIXM:  state_next = ST_N_MIXW;
      ST_N_MIXW:  if (mul_done) state_next = ST_N_RD;
      ST_N_RD:    state_next = ST_N_SINM;
      ST_N_SINM:  state_next = ST_N_SINW;
      ST_N_SINW:  if (mul_done) state_next = ST_ENV_M;
      ST_ENV_M:   state_next = ST_ENV_W;
      ST_ENV_W:   if (mul_done) state_next = ST_GAIN_M;
      ST_GAIN_M:  state_next = ST_GAIN_W;
      ST_GAIN_W: begin
        if (mul_done) begin
          if (fade_in) state_next = ST_FI_M;
          else if (fade_out) state_next = ST_FO_M;
          else state_next = ST_OUT;
        end
      end
      ST_FI_M:    state_next = ST_FI_W;
      ST_FI_W:    if (mul_done) state_next = ST_FI_DW;
      ST_FI_DW: begin
        if (div_done) state_next = fade_out ? ST_FO_M : ST_OUT;
      end
      ST_FO_M:    state_next = ST_FO_W;
      ST_FO_W:    if (mul_done) state_next = ST_FO_DW;
      ST_FO_DW:   if (div_done) state_next = ST_OUT;
      ST_OUT:     state_next = ST_DEC_W;
      ST_DEC_W:   if (mul_done) state_next = ST_EMIT;
      ST_EMIT:    if (emit_fire) state_next = ST_IDLE;
      default:    state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    mul_start = 1'b0;
    mul_a     = '0;
    mul_b     = '0;
    op_neg    = 1'b0;
    div_start = 1'b0;
    rom_pp    = 1'b0;
    unique case (state)
      ST_PHASE: begin
        mul_start = 1'b1;
        mul_a     = MUL_A_W'(phase_step);
        mul_b     = MUL_B_W'(PARTIAL_FRAC);
      end
      ST_W0_RD: rom_pp = 1'b1;
      ST_W0_MUL: begin
        mul_start = 1'b1;
        mul_a     = MUL_A_W'(rom_q);
        mul_b     = MUL_B_W'(K_PARTIAL);
        op_neg    = partial_phase[31];
      end
      ST_N_LPM: begin
        mul_start = 1'b1;
        mul_a     = MUL_A_W'(diff_abs);
        mul_b     = MUL_B_W'(K_LOWPASS);
        op_neg    = diff_q[25];
      end
      ST_N_MIXM: begin
        mul_start = 1'b1;
        mul_a     = MUL_A_W'(lp_abs);
        mul_b     = MUL_B_W'(K_NOISE_MIX);
        op_neg    = lowpass[24];
      end
      ST_N_SINM: begin
        mul_start = 1'b1;
        mul_a     = MUL_A_W'(rom_q);
        mul_b     = MUL_B_W'(K_SINE_MIX);
        op_neg    = phase[31];
      end
      ST_ENV_M: begin
        mul_start = 1'b1;
        mul_a     = v_abs[MUL_A_W-1:0];
        mul_b     = MUL_B_W'(envelope);
        op_neg    = v[V_W-1];
      end
      ST_GAIN_M: begin
        mul_start = 1'b1;
        mul_a     = v_abs[MUL_A_W-1:0];
        mul_b     = MUL_B_W'(output_gain);
        op_neg    = v[V_W-1];
      end
      ST_FI_M: begin
        mul_start = 1'b1;
        mul_a     = v_abs[MUL_A_W-1:0];
        mul_b     = MUL_B_W'(idx_q);
        op_neg    = v[V_W-1];
      end
      ST_FO_M: begin
        mul_start = 1'b1;
        mul_a     = v_abs[MUL_A_W-1:0];
        mul_b     = MUL_B_W'(rem_v);
        op_neg    = v[V_W-1];
      end
      ST_FI_W, ST_FO_W: div_start = mul_done;
      ST_OUT: begin
        mul_start = 1'b1;
        mul_a     = MUL_A_W'(envelope);
        mul_b     = MUL_B_W'(decay_ratio);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else state <= state_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= '0;
      partial_phase <= '0;
      phase_step    <= '0;
      sample_index  <= '0;
      envelope      <= 24'(Q_ONE);
      lowpass       <= '0;
      noise_word    <= NOISE_SEED;
      running       <= 1'b0;
      m_tvalid      <= 1'b0;
    end else begin
      if (emit_fire) m_tvalid <= 1'b1;
      else if (m_tready) m_tvalid <= 1'b0;
      if (mul_start) mul_neg <= op_neg;
      unique case (state)
        ST_IDLE: begin
          if (accept && s_tdata[0]) begin
            phase         <= '0;
            partial_phase <= '0;
            phase_step    <= step_start;
            sample_index  <= '0;
            envelope      <= 24'(Q_ONE);
            lowpass       <= '0;
            running       <= 1'b1;
          end
        end
        ST_PHASE: begin
          phase   <= phase + phase_step;
          idx_q   <= sample_index;
          count_q <= (count_raw == '0) ? CNT_W'(1) : count_raw;
        end
        ST_PFRAC: begin
          if (mul_done) begin
            partial_phase <= partial_phase + (phase_step << 1) + mul_prod[63:32];
            if (waveform == WAVE_TRIANGLE) v <= tri_v;
            else if (phase != '0 && !phase[31]) v <= $signed(V_W'(Q_ONE));
            else v <= -$signed(V_W'(Q_ONE));
          end
        end
        ST_W0_WAIT: if (mul_done) tmp <= s23;
        ST_W0_SUM:  v <= sine_s + tmp;
        ST_N_LFSR: begin
          noise_word <= nw3;
          diff_q     <= 26'(nz) - 26'(lowpass);
        end
        ST_N_LPW:  if (mul_done) lowpass <= lowpass + 25'(s23);
        ST_N_MIXW: if (mul_done) tmp <= s23;
        ST_N_SINW: if (mul_done) v <= tmp + s23;
        ST_ENV_W:  if (mul_done) v <= s23;
        ST_GAIN_W: if (mul_done) v <= s16;
        ST_FI_DW, ST_FO_DW: if (div_done) v <= q_s;
        ST_OUT: begin
          samp_q <= mag_q;
          last_q <= last_v;
        end
        ST_DEC_W: begin
          if (mul_done) envelope <= (env_r[65:23] > 43'hFFFFFF) ? 24'hFFFFFF : env_r[46:23];
        end
        ST_EMIT: begin
          if (emit_fire) begin
            m_tdata      <= samp_q;
            m_tlast      <= last_q;
            phase_step   <= phase_step + step_slope;
            sample_index <= idx_q + 1'b1;
            if (last_q) running <= 1'b0;
          end
        end
        default: ;
      endcase
    end
  end

  stsyn_smul u_mul (
    .clk   (clk),
    .rst   (rst),
    .start (mul_start),
    .a     (mul_a),
    .b     (mul_b),
    .done  (mul_done),
    .prod  (mul_prod)
  );

  stsyn_sdiv #(
    .DIVISOR (FADE_LENGTH)
  ) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .done  (div_done),
    .quot  (div_quot)
  );

endmodule
